/* sv/adf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adf_pkg: shared types for the advertising duplicate filter
// Command codes, the queued item word and the queue status bundle.
// ----------------------------------------------------------------------------
package adf_pkg;

  localparam int ADDR_W = 48;
  localparam int KIND_W = 2;

  // command codes
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one classified command word
  typedef struct packed {
    logic              is_clear;
    logic [ADDR_W-1:0] address;
    logic [KIND_W-1:0] kind;
    logic              named;
  } item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* sv/advert_duplicate_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// advert_duplicate_filter: duplicate filter for advertising reports
// Command intake, a two-word queue and a sequential table search.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word is taken at a rising edge with start high and busy low.
//   in_command = clear empties the table and opens a new window; a filter
//   command looks up address and kind. busy is high only while the two-word
//   queue is full, so up to two words may wait behind the one in progress.
//   Output: each result sits on out_report_pass / out_overflow for one cycle
//   with out_strobe high; the receiver cannot stall and results come in order.
//   Search: a clear only empties the table; a report is compared with the N
//   stored entries in order and the search stops early on a hit. The search
//   reads one table entry per cycle from the table memory.
//   Reset: the table is empty, the queue is flushed and no strobe is issued.
//   Table memory needs no clearing pass: only entries below the fill count
//   are ever read.
// ----------------------------------------------------------------------------
module advert_duplicate_filter #(
  parameter int TABLE_DEPTH = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_command,
  input  wire logic [adf_pkg::ADDR_W-1:0] in_device_address,
  input  wire logic [adf_pkg::KIND_W-1:0] in_address_kind,
  input  wire logic                       in_name_known,
  output logic                            out_strobe,
  output logic                            out_report_pass,
  output logic                            out_overflow
);

  adf_pkg::q_stat_t q_stat;
  adf_pkg::item_t   push_item;
  adf_pkg::item_t   head;
  logic             push;
  logic             pop;

  // intake and decode
  adf_front u_front (
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_device_address (in_device_address),
    .in_address_kind   (in_address_kind),
    .in_name_known     (in_name_known),
    .q_stat            (q_stat),
    .push              (push),
    .item              (push_item)
  );

  // decoupling queue
  adf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // table search engine
  adf_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head            (head),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_report_pass (out_report_pass),
    .out_overflow    (out_overflow)
  );

`ifndef SYNTHESIS
  // never push into a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("word pushed into full queue");

  // never pop an empty queue
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("word popped from empty queue");

  // an overflowing report is always forwarded
  a_ovf_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_overflow) |-> out_report_pass)
    else $error("overflow without pass");

  // a popped clear word strobes its result on the next cycle
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.is_clear) |=> (out_strobe && !out_report_pass && !out_overflow))
    else $error("clear result missing");
`endif

endmodule
`default_nettype wire

/* sv/adf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adf_front: command intake
// Takes a command word when the queue has room, decodes it and pushes it.
// ----------------------------------------------------------------------------
module adf_front (
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_command,
  input  wire logic [adf_pkg::ADDR_W-1:0] in_device_address,
  input  wire logic [adf_pkg::KIND_W-1:0] in_address_kind,
  input  wire logic                       in_name_known,
  input  wire adf_pkg::q_stat_t           q_stat,
  output logic                            push,
  output adf_pkg::item_t                  item
);

  // hold off while the queue is full
  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  // classify: a clear drops the report fields
  always_comb begin
    item.is_clear = (in_command == adf_pkg::CMD_CLEAR);
    if (item.is_clear) begin
      item.address = '0;
      item.kind    = '0;
      item.named   = 1'b0;
    end else begin
      item.address = in_device_address;
      item.kind    = in_address_kind;
      item.named   = in_name_known;
    end
  end

endmodule
`default_nettype wire

/* sv/adf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adf_queue: short command queue
// Two-entry FIFO that decouples intake from the table search.
// ----------------------------------------------------------------------------
module adf_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire adf_pkg::item_t   push_item,
  input  wire logic             pop,
  output adf_pkg::item_t        head,
  output adf_pkg::q_stat_t      q_stat
);

  adf_pkg::item_t                slots_r [adf_pkg::QDEPTH];
  logic [adf_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [adf_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [adf_pkg::QCNT_W-1:0]    cnt_r;
  logic [adf_pkg::QCNT_W-1:0]    cnt_nxt;

  assign q_stat.full  = (cnt_r == adf_pkg::QCNT_W'(adf_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = slots_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_item;
  end

endmodule
`default_nettype wire

/* sv/adf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adf_back: table search and update
// Clears, or walks entries one per cycle, then marks, appends or overflows.
// ----------------------------------------------------------------------------
module adf_back #(
  parameter int TABLE_DEPTH = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire adf_pkg::q_stat_t q_stat,
  input  wire adf_pkg::item_t   head,
  output logic                  pop,
  output logic                  out_strobe,
  output logic                  out_report_pass,
  output logic                  out_overflow
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [adf_pkg::ADDR_W-1:0] address;
    logic [adf_pkg::KIND_W-1:0] kind;
    logic                       named;
  } entry_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  entry_t         mem [TABLE_DEPTH];
  entry_t         rd_data_r;
  state_t         state_r;
  adf_pkg::item_t item_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic [CNT_W-1:0] cmp_idx_r;
  logic             cmp_vld_r;
  logic             strobe_r;
  logic             pass_r;
  logic             ovf_r;

  logic             issue;
  logic             hit;
  logic             last;
  logic             miss_now;
  logic             table_full;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign out_strobe      = strobe_r;
  assign out_report_pass = pass_r;
  assign out_overflow    = ovf_r;

  // compare stage, one entry behind the read
  assign pop        = (state_r == S_IDLE) && !q_stat.empty;
  assign issue      = (state_r == S_SEARCH) && (rd_idx_r < count_r);
  assign hit        = cmp_vld_r && (rd_data_r.address == item_r.address)
                      && (rd_data_r.kind == item_r.kind);
  assign last       = (CNT_W'(cmp_idx_r + CNT_W'(1)) == count_r);
  assign miss_now   = (state_r == S_SEARCH) && !hit
                      && ((count_r == '0) || (cmp_vld_r && last));
  assign table_full = (count_r >= CNT_W'(TABLE_DEPTH));

  // table write: mark a hit named, or append a new address
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx_r[IDX_W-1:0];
    wr_data = rd_data_r;
    if ((state_r == S_SEARCH) && hit) begin
      wr_en         = item_r.named && !rd_data_r.named;
      wr_data.named = 1'b1;
    end else if (miss_now && !table_full) begin
      wr_en   = 1'b1;
      wr_addr = count_r[IDX_W-1:0];
      wr_data = '{address: item_r.address, kind: item_r.kind, named: item_r.named};
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (issue) rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          cmp_vld_r <= 1'b0;
          if (pop) begin
            item_r <= head;
            if (head.is_clear) begin
              count_r  <= '0;
              strobe_r <= 1'b1;
              pass_r   <= 1'b0;
              ovf_r    <= 1'b0;
            end else begin
              rd_idx_r <= '0;
              state_r  <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          // issue the next read
          if (issue) begin
            cmp_vld_r <= 1'b1;
            cmp_idx_r <= rd_idx_r;
            rd_idx_r  <= rd_idx_r + 1'b1;
          end else begin
            cmp_vld_r <= 1'b0;
          end
          // finish on a hit or at the end of the table
          if (hit) begin
            strobe_r  <= 1'b1;
            pass_r    <= item_r.named && !rd_data_r.named;
            ovf_r     <= 1'b0;
            cmp_vld_r <= 1'b0;
            state_r   <= S_IDLE;
          end else if (miss_now) begin
            strobe_r  <= 1'b1;
            pass_r    <= 1'b1;
            ovf_r     <= table_full;
            if (!table_full) count_r <= count_r + 1'b1;
            cmp_vld_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for advert_duplicate_filter
// A driver replays a queue of command words through the start/busy handshake.
// Each accepted word is run through a local copy of the address table to work
// out the verdict. A monitor compares every strobed result against the oldest
// outstanding verdict. Stimulus is a directed opening, then randomised scan
// windows that draw reports from a device pool. Some pools overflow the table.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ADDR_W      = adf_pkg::ADDR_W;
  localparam int KIND_W      = adf_pkg::KIND_W;
  localparam int TABLE_DEPTH = 24;
  localparam int WORD_TARGET = 700;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  // one command word as queued for the driver
  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
    logic [KIND_W-1:0] kind;
    logic              named;
    bit                hold_for_drain;
  } filter_word_t;

  typedef struct packed {
    logic pass;
    logic ovf;
  } verdict_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_command;
  logic [ADDR_W-1:0] in_device_address;
  logic [KIND_W-1:0] in_address_kind;
  logic              in_name_known;
  logic              out_strobe;
  logic              out_report_pass;
  logic              out_overflow;

  filter_word_t pending_words [$];
  verdict_t     verdict_q [$];
  filter_word_t cur_word;

  // local copy of the address table
  logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
  logic [KIND_W-1:0] tbl_kind [TABLE_DEPTH];
  bit                tbl_named [TABLE_DEPTH];
  int                tbl_fill;

  int words_sent;
  int results_checked;
  int mismatch_count;
  int cycle_count;
  int n_clear, n_fresh, n_upgrade, n_dropped, n_overflow;

  advert_duplicate_filter #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_device_address(in_device_address),
    .in_address_kind  (in_address_kind),
    .in_name_known    (in_name_known),
    .out_strobe       (out_strobe),
    .out_report_pass  (out_report_pass),
    .out_overflow     (out_overflow)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // verdict for one word; updates the table copy as the block would
  function automatic verdict_t filter_verdict(input filter_word_t w);
    verdict_t v;
    int       hit;
    int       i;
    v.pass = 1'b0;
    v.ovf  = 1'b0;
    hit    = -1;
    if (w.command == adf_pkg::CMD_CLEAR) begin
      tbl_fill = 0;
      n_clear++;
      return v;
    end
    for (i = 0; i < tbl_fill; i++) begin
      if (hit < 0 && tbl_addr[i] == w.address && tbl_kind[i] == w.kind) hit = i;
    end
    if (hit >= 0) begin
      // known device: passes once more only when a name first turns up
      if (w.named && !tbl_named[hit]) begin
        tbl_named[hit] = 1'b1;
        v.pass = 1'b1;
        n_upgrade++;
      end else begin
        n_dropped++;
      end
    end else if (tbl_fill < TABLE_DEPTH) begin
      tbl_addr[tbl_fill]  = w.address;
      tbl_kind[tbl_fill]  = w.kind;
      tbl_named[tbl_fill] = w.named;
      tbl_fill++;
      v.pass = 1'b1;
      n_fresh++;
    end else begin
      // table full: forwarded but not stored
      v.pass = 1'b1;
      v.ovf  = 1'b1;
      n_overflow++;
    end
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_address();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  function automatic bit sender_idles();
    // no idling in the middle of the run
    if (words_sent >= 250 && words_sent < 400) return 1'b0;
    return $urandom_range(0, 99) < 22;
  endfunction

  task automatic push_word(input logic cmd, input logic [ADDR_W-1:0] addr,
                           input logic [KIND_W-1:0] kind, input logic named,
                           input bit drain);
    filter_word_t w;
    w.command        = cmd;
    w.address        = addr;
    w.kind           = kind;
    w.named          = named;
    w.hold_for_drain = drain;
    pending_words.push_back(w);
  endtask

  task automatic push_clear(input bit drain);
    push_word(adf_pkg::CMD_CLEAR, rand_address(), KIND_W'($urandom), 1'($urandom),
              drain);
  endtask

  // one scan window: usually a clear, then reports mostly drawn from a pool of devices
  task automatic queue_window(input bit force_big);
    logic [ADDR_W-1:0] pool_addr [$];
    logic [KIND_W-1:0] pool_kind [$];
    logic [ADDR_W-1:0] a;
    int                n_pool;
    int                n_rep;
    int                idx;
    int                r;
    int                sel;
    sel = force_big ? 2 : $urandom_range(0, 2);
    case (sel)
      0:       n_pool = $urandom_range(1, 8);
      1:       n_pool = $urandom_range(9, TABLE_DEPTH);
      default: n_pool = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 10);
    endcase
    for (r = 0; r < n_pool; r++) begin
      sel = $urandom_range(0, 9);
      if (r > 0 && sel < 2) begin
        // same address, with a freshly drawn kind
        a = pool_addr[$urandom_range(0, r - 1)];
      end else if (r > 0 && sel == 2) begin
        // near miss: one bit away from an existing device
        a = pool_addr[$urandom_range(0, r - 1)];
        a[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
      end else begin
        a = rand_address();
      end
      pool_addr.push_back(a);
      pool_kind.push_back(KIND_W'($urandom));
    end
    // occasionally carry the old table over, or clear twice
    if ($urandom_range(0, 99) >= 15) push_clear($urandom_range(0, 99) < 8);
    if ($urandom_range(0, 99) < 5) push_clear(1'b0);
    n_rep = n_pool + $urandom_range(n_pool, 2 * n_pool + 4);
    for (r = 0; r < n_rep; r++) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        push_clear(1'b0);
      end else if (sel < 13) begin
        push_word(adf_pkg::CMD_FILTER, rand_address(), KIND_W'($urandom),
                  1'($urandom), 1'b0);
      end else begin
        idx = (r < n_pool) ? r : $urandom_range(0, n_pool - 1);
        push_word(adf_pkg::CMD_FILTER, pool_addr[idx], pool_kind[idx],
                  $urandom_range(0, 99) < 30, 1'b0);
      end
    end
  endtask

  // driver: presents queued words and predicts each one as it is taken
  always @(posedge clk) begin : drive
    bit           present;
    filter_word_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      present = start;
      if (start && !busy) begin
        verdict_q.push_back(filter_verdict(cur_word));
        words_sent++;
        present = 1'b0;
      end
      if (!present) begin
        if (pending_words.size() > 0 &&
            !(pending_words[0].hold_for_drain && verdict_q.size() != 0) &&
            !sender_idles()) begin
          nxt      = pending_words.pop_front();
          cur_word = nxt;
          in_command        <= nxt.command;
          in_device_address <= nxt.address;
          in_address_kind   <= nxt.kind;
          in_name_known     <= nxt.named;
          start             <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic log_error(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, what);
  endtask

  // monitor: results are stable across the strobe cycle, sampled mid-cycle
  always @(negedge clk) begin : check
    verdict_t want;
    if (rst_n && out_strobe) begin
      if (verdict_q.size() == 0) begin
        log_error($sformatf("result with nothing outstanding: pass=%b ovf=%b",
                            out_report_pass, out_overflow));
      end else begin
        want = verdict_q.pop_front();
        results_checked++;
        if (out_report_pass !== want.pass || out_overflow !== want.ovf)
          log_error($sformatf("result %0d: expected pass=%b ovf=%b, got pass=%b ovf=%b",
                              results_checked, want.pass, want.ovf,
                              out_report_pass, out_overflow));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, verdict_q.size());
      $display("** advert_duplicate_filter: FAILED **");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [ADDR_W-1:0] ones;
    logic [ADDR_W-1:0] zero;
    ones = '1;
    zero = '0;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_command        = adf_pkg::CMD_FILTER;
    in_device_address = '0;
    in_address_kind   = '0;
    in_name_known     = 1'b0;

    // directed opening
    push_word(adf_pkg::CMD_CLEAR,  ones, 2'd3, 1'b1, 1'b0);  // fields ignored on clear
    push_word(adf_pkg::CMD_FILTER, zero, 2'd0, 1'b0, 1'b0);  // new
    push_word(adf_pkg::CMD_FILTER, zero, 2'd0, 1'b0, 1'b0);  // duplicate
    push_word(adf_pkg::CMD_FILTER, zero, 2'd0, 1'b1, 1'b0);  // name appears
    push_word(adf_pkg::CMD_FILTER, zero, 2'd0, 1'b1, 1'b0);  // already named
    push_word(adf_pkg::CMD_FILTER, zero, 2'd3, 1'b1, 1'b0);  // kind differs: new
    push_word(adf_pkg::CMD_FILTER, ones, 2'd3, 1'b0, 1'b0);
    push_word(adf_pkg::CMD_FILTER, ones, 2'd2, 1'b1, 1'b0);
    push_word(adf_pkg::CMD_FILTER, ones, 2'd3, 1'b1, 1'b0);  // name upgrade
    push_word(adf_pkg::CMD_FILTER, zero, 2'd1, 1'b0, 1'b0);
    push_word(adf_pkg::CMD_CLEAR,  zero, 2'd0, 1'b0, 1'b1);  // wait for drain first
    push_word(adf_pkg::CMD_CLEAR,  ones, 2'd1, 1'b0, 1'b0);  // repeated clear
    push_word(adf_pkg::CMD_FILTER, zero, 2'd0, 1'b1, 1'b0);  // new again after clear
    push_word(adf_pkg::CMD_FILTER, zero, 2'd0, 1'b0, 1'b0);
    push_word(adf_pkg::CMD_FILTER, 48'hAAAA_AAAA_AAAA, 2'd1, 1'b1, 1'b0);
    push_word(adf_pkg::CMD_FILTER, 48'h5555_5555_5555, 2'd2, 1'b0, 1'b0);
    push_word(adf_pkg::CMD_FILTER, 48'h5555_5555_5555, 2'd2, 1'b1, 1'b0);
    push_word(adf_pkg::CMD_FILTER, 48'h8000_0000_0000, 2'd0, 1'b0, 1'b0);
    push_word(adf_pkg::CMD_FILTER, 48'h0000_0000_0001, 2'd0, 1'b0, 1'b0);

    // random windows, the first one large enough to fill the table
    queue_window(1'b1);
    while (pending_words.size() < WORD_TARGET) queue_window(1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || start || verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) log_error("verdicts left outstanding at end of run");

    $display("run covered %0d words: %0d clears, %0d new devices, %0d name upgrades,",
             words_sent, n_clear, n_fresh, n_upgrade);
    $display("%0d duplicates dropped, %0d table overflows; %0d results checked",
             n_dropped, n_overflow, results_checked);
    if (mismatch_count == 0) begin
      $display("** advert_duplicate_filter: PASSED **");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("** advert_duplicate_filter: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/adf_pkg.sv
sv/adf_front.sv
sv/adf_queue.sv
sv/adf_back.sv
sv/advert_duplicate_filter.sv
tb/testbench.sv
